/* sv/upd_pkg.sv */
// Shared types, constants and helper functions of the URL percent decoder.
package upd_pkg;

  localparam int UPD_FIFO_DEPTH = 4;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // Up to three decoded bytes produced by one input beat.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } fifo_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
    job_t head;
  } fifo_rd_t;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
             (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    hex_val = (b <= 8'h39) ? b[3:0] : b[3:0] + 4'd9;
  endfunction

endpackage

/* sv/upd_in_if.sv */
// Input channel of the decoder: one encoded byte per beat.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source(output valid, output in_byte, output in_last, input ready);
  modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

/* sv/upd_out_if.sv */
// Output channel of the decoder: one decoded byte per beat.
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source(output valid, output out_byte, output out_last, input ready);
  modport sink(input valid, input out_byte, input out_last, output ready);
endinterface

/* sv/url_percent_decoder.sv */
// Top level of the streaming URL percent decoder.
// The enc channel takes one byte of a form-urlencoded string per beat, with
// in_last set on the final byte. The dec channel gives the decoded bytes one
// per beat, with out_last set on the final decoded byte of the string.
// A plus sign becomes a space, and a percent sign with two hex digits becomes
// the byte they spell; a broken or unfinished escape is passed on literally.
// The front end accepts one beat per cycle while the queue is not full and
// turns it into a job of zero to three output bytes for a FIFO_DEPTH-entry
// queue. The back end empties one job byte per cycle into the output register
// while the receiver takes its beats. A byte that yields output passes the
// queue, the back end's job register and the output register to reach dec.
// Throughput is one input beat per cycle while each beat yields at most one
// byte and dec is ready; the output port, at one beat per cycle, sets the
// limit when escapes are broken. Reset clears the escape state, the queue
// and the output register. When the receiver stalls, the output register
// holds its beat, the queue fills, and enc.ready drops once the queue is full.
module url_percent_decoder import upd_pkg::*; #(
  parameter int FIFO_DEPTH = UPD_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  upd_in_if.sink    enc,
  upd_out_if.source dec
);

  fifo_wr_t wr;
  fifo_rd_t rd;
  logic     pop;

  upd_front u_front (
    .clk (clk),
    .rst (rst),
    .enc (enc),
    .rd  (rd),
    .wr  (wr)
  );

  upd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk (clk),
    .rst (rst),
    .wr  (wr),
    .pop (pop),
    .rd  (rd)
  );

  upd_back u_back (
    .clk (clk),
    .rst (rst),
    .rd  (rd),
    .pop (pop),
    .dec (dec)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    wr.push |-> !rd.full)
    else $error("Job queue written while full.");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !rd.empty)
    else $error("Job queue read while empty.");

  a_last_yields: assert property (@(posedge clk) disable iff (rst)
    (enc.valid && enc.ready && enc.in_last) |-> (wr.push && wr.job.last))
    else $error("Final beat of a string produced no job.");

  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    wr.push |-> (wr.job.cnt != 2'd0))
    else $error("Empty job pushed into the queue.");

endmodule

/* sv/upd_front.sv */
// Front end: accepts encoded bytes, tracks escapes and builds decode jobs.
module upd_front import upd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  upd_in_if.sink   enc,
  input  fifo_rd_t rd,
  output fifo_wr_t wr
);

  phase_t     phase, phase_next;
  logic [7:0] held, held_next;
  job_t       job;
  logic       accept;

  assign enc.ready = !rd.full;
  assign accept    = enc.valid && enc.ready;

  always_comb begin
    logic [1:0] n;
    logic       plain;
    n          = 2'd0;
    plain      = 1'b0;
    job        = '0;
    phase_next = phase;
    held_next  = held;
    case (phase)
      PH_PCT: begin
        if (is_hex(enc.in_byte)) begin
          if (!enc.in_last) begin
            phase_next = PH_DIGIT;
            held_next  = enc.in_byte;
          end else begin
            job.bytes[0] = CH_PERCENT;
            job.bytes[1] = enc.in_byte;
            n            = 2'd2;
          end
        end else begin
          job.bytes[0] = CH_PERCENT;
          n            = 2'd1;
          plain        = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (is_hex(enc.in_byte)) begin
          job.bytes[0] = {hex_val(held), hex_val(enc.in_byte)};
          n            = 2'd1;
          phase_next   = PH_IDLE;
          held_next    = '0;
        end else begin
          job.bytes[0] = CH_PERCENT;
          job.bytes[1] = held;
          n            = 2'd2;
          plain        = 1'b1;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase
    if (plain) begin
      phase_next = PH_IDLE;
      held_next  = '0;
      if (enc.in_byte == CH_PERCENT) begin
        if (enc.in_last) begin
          job.bytes[n] = CH_PERCENT;
          n            = n + 2'd1;
        end else begin
          phase_next = PH_PCT;
        end
      end else if (enc.in_byte == CH_PLUS) begin
        job.bytes[n] = CH_SPACE;
        n            = n + 2'd1;
      end else begin
        job.bytes[n] = enc.in_byte;
        n            = n + 2'd1;
      end
    end
    if (enc.in_last) begin
      phase_next = PH_IDLE;
      held_next  = '0;
    end
    job.cnt  = n;
    job.last = enc.in_last;
  end

  assign wr.push = accept && (job.cnt != 2'd0);
  assign wr.job  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule

/* sv/upd_fifo.sv */
// Short job queue between the front end and the back end.
module upd_fifo import upd_pkg::*; #(
  parameter int DEPTH = UPD_FIFO_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  fifo_wr_t wr,
  input  logic     pop,
  output fifo_rd_t rd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign rd.full  = (count == CW'(DEPTH));
  assign rd.empty = (count == '0);
  assign rd.head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr.push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !wr.push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* sv/upd_back.sv */
// Back end: unpacks queued jobs into single output beats.
module upd_back import upd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  fifo_rd_t rd,
  output logic     pop,
  upd_out_if.source dec
);

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       emit;
  logic       fin;

  assign dec.valid    = out_valid;
  assign dec.out_byte = out_byte;
  assign dec.out_last = out_last;

  assign emit = cur_valid && (!out_valid || dec.ready);
  assign fin  = emit && (idx == cur.cnt - 2'd1);
  assign pop  = !rd.empty && (!cur_valid || fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (fin) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (emit) begin
        idx <= idx + 2'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (dec.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd.head;
    end
    if (emit) begin
      out_byte <= cur.bytes[idx];
      out_last <= cur.last && (idx == cur.cnt - 2'd1);
    end
  end

endmodule
